// ----- rtl/hbc_pkg.sv -----
package hbc_pkg;

	localparam int unsigned BucketsDefault = 13;
	localparam int unsigned WaysDefault    = 8;

	typedef enum logic [1:0] {
		MODE_GET     = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_PIN     = 2'd2,
		MODE_UNPIN   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_HIT       = 3'd0,
		ST_MISS      = 3'd1,
		ST_NO_FREE   = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_OVERFLOW  = 3'd4,
		ST_DONE      = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_READ,
		FSM_SCAN,
		FSM_DECIDE,
		FSM_RANK,
		FSM_WRITE
	} fsm_t;

endpackage

// ----- rtl/hbc_ram.sv -----
module hbc_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/hashed_block_cache_tag_lru.sv -----
// Tag and LRU engine for a hashed block cache.
// Command channel: drive mode, device, block_number, handle_bucket and
// handle_way with start high; the beat is taken at an edge where busy is low.
// Result channel: one result per command, shown for one cycle with
// done high. The receiver cannot stall; each result must be taken then.
// A get first reduces block_number modulo BUCKETS by folding byte residues
// and a reciprocal multiply, then walks the WAYS entries of its bucket, one
// read per cycle, then decides and writes back. Release, pin and unpin on a
// valid handle skip the reduction. A release that drops the count to zero
// walks the bucket once more to reorder it. An out-of-range handle skips the
// walk and answers directly. busy falls with done, so the next command may
// be taken in the result cycle; one command is in flight.
// Entry state (tag, valid, count, rank) lives in one memory of
// BUCKETS*WAYS words with registered reads. After reset a clearing pass
// writes every entry; busy stays high during it.
module hashed_block_cache_tag_lru
	import hbc_pkg::*;
#(
	parameter int unsigned Buckets = BucketsDefault,
	parameter int unsigned Ways    = WaysDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [15:0] device,
	input  logic [31:0] block_number,
	input  logic [3:0]  handle_bucket,
	input  logic [2:0]  handle_way,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  entry_bucket,
	output logic [2:0]  entry_way,
	output logic        need_read,
	output logic [7:0]  ref_count
);

	localparam int unsigned Entries = Buckets * Ways;
	localparam int unsigned AW = (Entries > 1) ? $clog2(Entries) : 1;
	localparam int unsigned WW = (Ways > 1) ? $clog2(Ways) : 1;
	localparam int unsigned BW = (Buckets > 1) ? $clog2(Buckets) : 1;
	localparam int unsigned CW = $clog2(Ways + 1);
	localparam int unsigned DW = 16 + 32 + 1 + 8 + WW;
	localparam int unsigned R1 = 256 % Buckets;
	localparam int unsigned R2 = 65536 % Buckets;
	localparam int unsigned R3 = 16777216 % Buckets;
	localparam logic [32:0] Recip =
		33'(((64'd1 << 32) + 64'(Buckets) - 64'd1) / 64'(Buckets));

	// memory word: {dev, blk, valid, refs, rank}
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [DW-1:0] wdata, rdata;

	hbc_ram #(.Width(DW), .Depth(Entries)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	fsm_t          st_q, st_d;
	logic [AW:0]   clr_q;
	logic [WW-1:0] clr_way_q;
	logic          clr_busy;
	logic [1:0]    mode_q;
	logic [15:0]   dev_q;
	logic [31:0]   blk_q;
	logic [3:0]    bkt_q;
	logic [2:0]    hw_q;
	logic [CW-1:0] idx_q;      // read index
	logic [CW-1:0] cnt_q;      // returned words
	logic          pend_q;     // read in flight
	logic [WW-1:0] pway_q;     // way of the in-flight read
	logic          hit_q, fr_q, mine_q;
	logic [WW-1:0] hway_q, fway_q;
	logic [WW-1:0] hrank_q, frank_q;
	logic [DW-1:0] hword_q, fword_q, mword_q;
	logic [WW-1:0] tway_q;     // target way
	logic [WW-1:0] trank_q;    // target old rank
	logic          promo_q;    // release to zero: reorder
	logic [DW-1:0] tword_q;    // new target word
	logic [BW-1:0] bidx;

	// bucket = block mod Buckets: fold byte residues, then reciprocal multiply
	logic [15:0]   fold_q;
	logic [15:0]   quo_q;
	logic [5:0]    rbit_q;

	logic [15:0]   r_dev;
	logic [31:0]   r_blk;
	logic          r_val;
	logic [7:0]    r_refs;
	logic [WW-1:0] r_rank;

	assign r_dev  = rdata[DW-1 -: 16];
	assign r_blk  = rdata[DW-17 -: 32];
	assign r_val  = rdata[8+WW];
	assign r_refs = rdata[WW +: 8];
	assign r_rank = rdata[WW-1:0];

	assign clr_busy = (clr_q < (AW+1)'(Entries));
	assign busy     = clr_busy || (st_q != FSM_IDLE);
	assign bidx     = BW'(bkt_q);

	logic          accept;
	logic          hin;
	assign accept = start && !busy;
	assign hin    = (32'(handle_bucket) < Buckets) && (32'(handle_way) < Ways);

	logic scan_end, rank_end;
	assign scan_end = (cnt_q == CW'(Ways));
	assign rank_end = scan_end;

	always_comb begin
		st_d = st_q;
		case (st_q)
			FSM_IDLE:   if (accept) begin
				if (mode_t'(mode) == MODE_GET) st_d = FSM_READ;
				else if (hin) st_d = FSM_SCAN;
				else st_d = FSM_WRITE;
			end
			FSM_READ:   if (rbit_q == 6'd2) st_d = FSM_SCAN;
			FSM_SCAN:   if (scan_end) st_d = FSM_DECIDE;
			FSM_DECIDE: st_d = FSM_RANK;
			FSM_RANK:   if (!promo_q || rank_end) st_d = FSM_WRITE;
			FSM_WRITE:  st_d = FSM_IDLE;
			default:    st_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = AW'(clr_q);
		wdata = {16'd0, 32'd0, 1'b0, 8'd0, WW'(Ways - 1) - clr_way_q};
		raddr = AW'(bidx * Ways + 32'(idx_q[WW-1:0]));
		if (clr_busy) begin
			we = 1'b1;
		end else if (st_q == FSM_RANK && promo_q && pend_q && pway_q != tway_q
				&& r_rank < trank_q) begin
			we    = 1'b1;
			waddr = AW'(bidx * Ways + 32'(pway_q));
			wdata = {rdata[DW-1:WW], r_rank + WW'(1)};
		end else if (st_q == FSM_WRITE && mine_q) begin
			we    = 1'b1;
			waddr = AW'(bidx * Ways + 32'(tway_q));
			wdata = tword_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= FSM_IDLE;
			clr_q     <= '0;
			clr_way_q <= '0;
			done      <= 1'b0;
		end else begin
			st_q <= st_d;
			if (clr_busy) begin
				clr_q     <= clr_q + 1'b1;
				clr_way_q <= (clr_way_q == WW'(Ways - 1)) ? '0 : clr_way_q + 1'b1;
			end
			done <= (st_q == FSM_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			FSM_IDLE: begin
				mode_q  <= mode;
				dev_q   <= device;
				blk_q   <= block_number;
				bkt_q   <= handle_bucket;
				hw_q    <= handle_way;
				rbit_q  <= '0;
				idx_q   <= '0;
				cnt_q   <= '0;
				pend_q  <= 1'b0;
				hit_q   <= 1'b0;
				fr_q    <= 1'b0;
				mine_q  <= 1'b0;
				promo_q <= 1'b0;
				status  <= ST_DONE;
				entry_bucket <= handle_bucket;
				entry_way    <= handle_way;
				need_read    <= 1'b0;
				ref_count    <= 8'd0;
			end
			FSM_READ: begin
				rbit_q <= rbit_q + 6'd1;
				case (rbit_q)
					6'd0: fold_q <= 16'(32'(blk_q[7:0]) + 32'(blk_q[15:8]) * R1 +
						32'(blk_q[23:16]) * R2 + 32'(blk_q[31:24]) * R3);
					6'd1: quo_q <= 16'((49'(fold_q) * 49'(Recip)) >> 32);
					default: bkt_q <= 4'(32'(fold_q) - 32'(quo_q) * Buckets);
				endcase
			end
			FSM_SCAN: begin
				if (32'(idx_q) < Ways) idx_q <= idx_q + 1'b1;
				pend_q <= (32'(idx_q) < Ways);
				pway_q <= idx_q[WW-1:0];
				if (pend_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (pway_q == WW'(hw_q)) mword_q <= rdata;
					if (r_dev == dev_q && r_blk == blk_q && (!hit_q || r_rank < hrank_q)) begin
						hit_q <= 1'b1; hway_q <= pway_q; hrank_q <= r_rank; hword_q <= rdata;
					end
					if (r_refs == 8'd0 && (!fr_q || r_rank > frank_q)) begin
						fr_q <= 1'b1; fway_q <= pway_q; frank_q <= r_rank; fword_q <= rdata;
					end
				end
			end
			FSM_DECIDE: begin
				idx_q  <= '0;
				cnt_q  <= '0;
				pend_q <= 1'b0;
				entry_bucket <= bkt_q;
				if (mode_t'(mode_q) == MODE_GET) begin
					if (hit_q) begin
						tway_q <= hway_q;
						entry_way <= 3'(hway_q);
						if (hword_q[WW +: 8] == 8'd255) begin
							status <= ST_OVERFLOW; ref_count <= 8'd255;
						end else begin
							mine_q  <= 1'b1;
							status  <= ST_HIT;
							need_read <= !hword_q[8+WW];
							ref_count <= hword_q[WW +: 8] + 8'd1;
							tword_q <= {hword_q[DW-1 -: 48], 1'b1,
								hword_q[WW +: 8] + 8'd1, hword_q[WW-1:0]};
						end
					end else if (fr_q) begin
						mine_q  <= 1'b1;
						tway_q  <= fway_q;
						entry_way <= 3'(fway_q);
						status  <= ST_MISS; need_read <= 1'b1; ref_count <= 8'd1;
						tword_q <= {dev_q, blk_q, 1'b1, 8'd1, fword_q[WW-1:0]};
					end else begin
						status <= ST_NO_FREE; entry_way <= 3'd0;
					end
				end else begin
					tway_q  <= WW'(hw_q);
					trank_q <= mword_q[WW-1:0];
					if (mode_t'(mode_q) == MODE_PIN) begin
						if (mword_q[WW +: 8] == 8'd255) begin
							status <= ST_OVERFLOW; ref_count <= 8'd255;
						end else begin
							mine_q <= 1'b1; ref_count <= mword_q[WW +: 8] + 8'd1;
							tword_q <= {mword_q[DW-1:WW+8], mword_q[WW +: 8] + 8'd1,
								mword_q[WW-1:0]};
						end
					end else if (mword_q[WW +: 8] == 8'd0) begin
						status <= ST_UNDERFLOW;
					end else begin
						mine_q <= 1'b1; ref_count <= mword_q[WW +: 8] - 8'd1;
						promo_q <= (mode_t'(mode_q) == MODE_RELEASE) &&
							(mword_q[WW +: 8] == 8'd1);
						tword_q <= {mword_q[DW-1:WW+8], mword_q[WW +: 8] - 8'd1,
							(mode_t'(mode_q) == MODE_RELEASE && mword_q[WW +: 8] == 8'd1) ?
							WW'(0) : mword_q[WW-1:0]};
					end
				end
			end
			FSM_RANK: begin
				if (32'(idx_q) < Ways) idx_q <= idx_q + 1'b1;
				pend_q <= (32'(idx_q) < Ways);
				pway_q <= idx_q[WW-1:0];
				if (pend_q) cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done misplaced");
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("busy not raised after accept");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == FSM_WRITE) |=> done && st_q == FSM_IDLE)
		else $error("result not issued after write");
	assert property (@(posedge clk) disable iff (!arst_n) clr_busy |-> !done)
		else $error("result during clearing pass");

endmodule

// ----- tb/hashed_block_cache_tag_lru_test.sv -----
module hashed_block_cache_tag_lru_test;
	import hbc_pkg::*;

	localparam int NB = 13;
	localparam int NW = 8;
	localparam int NE = NB * NW;

	typedef struct packed {
		status_t    st;
		logic [3:0] bkt;
		logic [2:0] way;
		logic       nr;
		logic [7:0] cnt;
	} cache_reply_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  mode;
	logic [15:0] device;
	logic [31:0] block_number;
	logic [3:0]  handle_bucket;
	logic [2:0]  handle_way;
	logic        done;
	logic [2:0]  status;
	logic [3:0]  entry_bucket;
	logic [2:0]  entry_way;
	logic        need_read;
	logic [7:0]  ref_count;

	logic [15:0] m_dev [NE];
	logic [31:0] m_blk [NE];
	logic        m_valid [NE];
	logic [7:0]  m_refs [NE];
	logic [2:0]  m_rank [NE];

	cache_reply_t pending_replies[$];
	int errors;
	int replies_seen;
	int beats_sent;
	bit idle_enable;
	logic [15:0] hot_dev [8];
	logic [31:0] hot_blk [8];

	hashed_block_cache_tag_lru uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.device(device), .block_number(block_number), .handle_bucket(handle_bucket),
		.handle_way(handle_way), .done(done), .status(status),
		.entry_bucket(entry_bucket), .entry_way(entry_way), .need_read(need_read),
		.ref_count(ref_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void cache_clear();
		for (int e = 0; e < NE; e++) begin
			m_dev[e] = '0;
			m_blk[e] = '0;
			m_valid[e] = 1'b0;
			m_refs[e] = '0;
			m_rank[e] = 3'(NW - 1 - (e % NW));
		end
	endfunction

	function automatic cache_reply_t cache_predict(mode_t md, logic [15:0] dv,
			logic [31:0] bn, logic [3:0] hb, logic [2:0] hw);
		cache_reply_t r;
		int fnd;
		int best;
		int base;
		int e;
		logic [2:0] old;
		r = '{st: ST_DONE, bkt: hb, way: hw, nr: 1'b0, cnt: 8'd0};
		if (md == MODE_GET) begin
			base = int'(bn % NB) * NW;
			r.bkt = 4'(bn % NB);
			fnd = -1;
			best = 0;
			for (int w = 0; w < NW; w++)
				if (m_dev[base + w] == dv && m_blk[base + w] == bn &&
						(fnd < 0 || m_rank[base + w] < best)) begin
					fnd = w;
					best = m_rank[base + w];
				end
			if (fnd >= 0) begin
				e = base + fnd;
				r.way = 3'(fnd);
				if (m_refs[e] == 8'd255) begin
					r.st = ST_OVERFLOW;
					r.cnt = 8'd255;
				end else begin
					m_refs[e]++;
					r.st = ST_HIT;
					r.nr = ~m_valid[e];
					m_valid[e] = 1'b1;
					r.cnt = m_refs[e];
				end
				return r;
			end
			for (int w = 0; w < NW; w++)
				if (m_refs[base + w] == 0 && (fnd < 0 || m_rank[base + w] > best)) begin
					fnd = w;
					best = m_rank[base + w];
				end
			if (fnd < 0) begin
				r.st = ST_NO_FREE;
				r.way = '0;
				return r;
			end
			e = base + fnd;
			m_dev[e] = dv;
			m_blk[e] = bn;
			m_refs[e] = 8'd1;
			m_valid[e] = 1'b1;
			r = '{st: ST_MISS, bkt: 4'(bn % NB), way: 3'(fnd), nr: 1'b1, cnt: 8'd1};
			return r;
		end
		if (hb >= NB || hw >= NW) return r;
		e = hb * NW + hw;
		if (md == MODE_PIN) begin
			if (m_refs[e] == 8'd255) begin
				r.st = ST_OVERFLOW;
				r.cnt = 8'd255;
				return r;
			end
			m_refs[e]++;
		end else begin
			if (m_refs[e] == 0) begin
				r.st = ST_UNDERFLOW;
				return r;
			end
			m_refs[e]--;
			if (md == MODE_RELEASE && m_refs[e] == 0) begin
				old = m_rank[e];
				for (int w = 0; w < NW; w++)
					if (m_rank[hb * NW + w] < old) m_rank[hb * NW + w]++;
				m_rank[e] = '0;
			end
		end
		r.cnt = m_refs[e];
		return r;
	endfunction

	task automatic send_beat(mode_t md, logic [15:0] dv, logic [31:0] bn,
			logic [3:0] hb, logic [2:0] hw);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		mode <= md;
		device <= dv;
		block_number <= bn;
		handle_bucket <= hb;
		handle_way <= hw;
		do @(posedge clk); while (busy);
		pending_replies.push_back(cache_predict(md, dv, bn, hb, hw));
		beats_sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cache_reply_t got;
		cache_reply_t exp;
		if (arst_n && done) begin
			got = '{st: status_t'(status), bkt: entry_bucket, way: entry_way,
				nr: need_read, cnt: ref_count};
			replies_seen++;
			if (pending_replies.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected reply %p", got);
			end else begin
				exp = pending_replies.pop_front();
				if (got !== exp) begin
					errors++;
					if (errors <= 10) $display("mismatch exp %p got %p", exp, got);
				end
			end
		end
	end

	function automatic logic [31:0] blk_in(int b);
		return 32'($urandom_range(0, 20)) * NB + b;
	endfunction

	task automatic test_directed();
		send_beat(MODE_GET, 16'd0, 32'd0, 4'd0, 3'd0);
		send_beat(MODE_GET, 16'd0, 32'd0, 4'd0, 3'd0);
		send_beat(MODE_GET, 16'd0, 32'd13, 4'd0, 3'd0);
		send_beat(MODE_GET, 16'hFFFF, 32'hFFFF_FFFF, 4'd0, 3'd0);
		send_beat(MODE_RELEASE, 16'd0, 32'd0, 4'd0, 3'd7);
		send_beat(MODE_RELEASE, 16'd0, 32'd0, 4'd0, 3'd7);
		send_beat(MODE_UNPIN, 16'd0, 32'd0, 4'd0, 3'd7);
		send_beat(MODE_UNPIN, 16'd0, 32'd0, 4'd5, 3'd2);
		send_beat(MODE_PIN, 16'd0, 32'd0, 4'd12, 3'd7);
		send_beat(MODE_PIN, 16'd0, 32'd0, 4'd13, 3'd1);
		send_beat(MODE_RELEASE, 16'd0, 32'd0, 4'd15, 3'd7);
		send_beat(MODE_UNPIN, 16'd0, 32'd0, 4'd14, 3'd0);
		send_beat(MODE_RELEASE, 16'd0, 32'd0, 4'd12, 3'd7);
		send_beat(MODE_RELEASE, 16'd0, 32'd0, 4'd0, 3'd6);
	endtask

	task automatic test_no_free();
		for (int i = 0; i < 9; i++)
			send_beat(MODE_GET, 16'(i + 1), 32'(i * NB + 3), 4'd0, 3'd0);
		for (int w = 0; w < NW; w++)
			send_beat(MODE_RELEASE, 16'd0, 32'd0, 4'd3, 3'(w));
		send_beat(MODE_GET, 16'd9, 32'(8 * NB + 3), 4'd0, 3'd0);
	endtask

	task automatic test_overflow();
		send_beat(MODE_GET, 16'h1234, 32'd7, 4'd0, 3'd0);
		for (int i = 0; i < 256; i++) send_beat(MODE_PIN, 16'd0, 32'd0, 4'd7, 3'd7);
		send_beat(MODE_GET, 16'h1234, 32'd7, 4'd0, 3'd0);
		for (int i = 0; i < 256; i++) send_beat(MODE_UNPIN, 16'd0, 32'd0, 4'd7, 3'd7);
	endtask

	task automatic test_random(int n);
		int k;
		int b;
		for (int i = 0; i < n; i++) begin
			if (i > n - 150) idle_enable = 1'b0;
			k = $urandom_range(0, 99);
			b = $urandom_range(0, NB - 1);
			if (k < 35) begin
				b = $urandom_range(0, 7);
				send_beat(MODE_GET, hot_dev[b], hot_blk[b], 4'($urandom), 3'($urandom));
			end else if (k < 45)
				send_beat(MODE_GET, 16'($urandom), $urandom, 4'($urandom), 3'($urandom));
			else if (k < 50)
				send_beat(MODE_GET, 16'($urandom_range(0, 3)), blk_in(b), 4'd0, 3'd0);
			else if (k < 80)
				send_beat(MODE_RELEASE, 16'($urandom), $urandom,
					4'($urandom_range(0, NB - 1)), 3'($urandom));
			else if (k < 88)
				send_beat(MODE_PIN, 16'($urandom), $urandom,
					4'($urandom_range(0, NB - 1)), 3'($urandom));
			else if (k < 96)
				send_beat(MODE_UNPIN, 16'($urandom), $urandom,
					4'($urandom_range(0, NB - 1)), 3'($urandom));
			else
				send_beat(mode_t'($urandom_range(1, 3)), 16'($urandom), $urandom,
					4'($urandom_range(NB, 15)), 3'($urandom));
		end
	endtask

	initial begin
		int guard;
		errors = 0;
		replies_seen = 0;
		beats_sent = 0;
		idle_enable = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		mode = '0;
		device = '0;
		block_number = '0;
		handle_bucket = '0;
		handle_way = '0;
		cache_clear();
		for (int i = 0; i < 8; i++) begin
			hot_dev[i] = 16'($urandom_range(0, 2));
			hot_blk[i] = (i < 4) ? 32'($urandom_range(0, 60)) : $urandom;
		end
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_no_free();
		test_overflow();
		test_random(904);
		start <= 1'b0;
		guard = 0;
		while (pending_replies.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
		$display("sent %0d commands, checked %0d replies (hits, misses, full buckets,",
			beats_sent, replies_seen);
		$display("count limits and out-of-range handles)");
		if (errors == 0 && pending_replies.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
